// ===== sv/stl_pkg.sv =====
// Package for the hash-map lookup/insert block: request/result structs,
// status codes, geometry constants and the controller state enum.
// No dependencies.
package stl_pkg;

	localparam int CAPACITY_DEF = 128;
	localparam int GROUP_SLOTS_DEF = 16;
	localparam logic [7:0] EMPTY_MARK = 8'h80;
	localparam int TAG_SHIFT = 25;
	localparam logic [7:0] LOAD_LIMIT_RST = 8'd112;

	typedef enum logic [2:0] {
		ST_FOUND    = 3'd0,
		ST_MISSING  = 3'd1,
		ST_UPDATED  = 3'd2,
		ST_INSERTED = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [63:0] key;
		logic [63:0] hash_value;
		logic [63:0] write_value;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] read_value;
		logic [6:0]  slot;
		logic [7:0]  entry_total;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CHECK,
		S_WRITE,
		S_DONE
	} fsm_t;

endpackage

// ===== sv/stl_ctrl_mem.sv =====
// Control byte memory, one byte per slot.
// One synchronous memory with a registered read; depends on stl_pkg.
module stl_ctrl_mem #(
	parameter int CAPACITY = stl_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [CAPACITY];

	// Write and read the control byte of one slot
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/stl_kv_mem.sv =====
// Key and value memory, one entry per slot, packed as one 128-bit word.
// Synchronous write and registered read; depends on stl_pkg.
module stl_kv_mem #(
	parameter int CAPACITY = stl_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [127:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [127:0]  rdata
);

	logic [127:0] mem [CAPACITY];

	// Write and read one key/value pair
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/swiss_table_lookup_insert.sv =====
// Hash map lookup/insert: one slot of the probe is read per cycle. A request is taken in
// IDLE, its slots are read and compared in READ until a hit or the probe ends, CHECK
// writes the entry on an insert and forms the result, and DONE shows it until taken.
// One request at a time, set by the single read port; a stalled result holds the input.
// After arst_n falls the control memory is swept to empty, taking no request; load_limit
// resets to 112. Depends on stl_pkg, stl_ctrl_mem and stl_kv_mem.
module swiss_table_lookup_insert #(
	parameter int CAPACITY = stl_pkg::CAPACITY_DEF,
	parameter int GROUP_SLOTS = stl_pkg::GROUP_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  stl_pkg::req_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output stl_pkg::rsp_t  out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [7:0]     cfg_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int GW = $clog2(GROUP_SLOTS);
	localparam int CW = AW + 1;

	stl_pkg::fsm_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [7:0]    load_limit_q;
	logic [CW-1:0] count_q;
	stl_pkg::req_t req_q;
	logic [63:0]   habs;
	logic [AW-1:0] in_base;
	logic [6:0]    tag_q;
	logic [CW-1:0] probed_q;  // slots read so far
	logic          have_empty_q;
	logic [AW-1:0] empty_q;
	logic [AW-1:0] rd_slot_s1;
	logic [GW-1:0] rd_idx_s1;
	logic          rd_valid_s1;
	logic          hit_q;
	logic [AW-1:0] hit_slot_q;
	logic [63:0]   hit_val_q;
	stl_pkg::rsp_t rsp_q;

	logic          c_we;
	logic [AW-1:0] c_waddr;
	logic [7:0]    c_wdata;
	logic [AW-1:0] raddr;
	logic [7:0]    c_rdata;
	logic          kv_we;
	logic [127:0]  kv_rdata;
	logic          accept;
	logic          is_hit;
	logic          slot_free;
	logic          last_in_group;
	logic          probe_end;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != stl_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = (state_q == stl_pkg::S_DONE);
	assign out_data = rsp_q;
	assign habs = in_data.hash_value[63] ? (64'd0 - in_data.hash_value) : in_data.hash_value;
	assign in_base = habs[AW-1:0] & ~AW'(GROUP_SLOTS - 1);

	// Compare the slot read last cycle
	assign is_hit = rd_valid_s1 && (c_rdata == {1'b0, tag_q})
		&& (kv_rdata[127:64] == req_q.key);
	assign slot_free = rd_valid_s1 && (c_rdata == stl_pkg::EMPTY_MARK);
	assign last_in_group = rd_valid_s1 && (rd_idx_s1 == GW'(GROUP_SLOTS - 1));
	assign probe_end = last_in_group && (have_empty_q || slot_free
		|| probed_q >= CW'(CAPACITY));

	stl_ctrl_mem #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(raddr), .rdata(c_rdata)
	);

	stl_kv_mem #(.CAPACITY(CAPACITY)) u_kv (
		.clk(clk), .we(kv_we), .waddr(hit_q ? hit_slot_q : empty_q),
		.wdata({req_q.key, req_q.write_value}), .raddr(raddr), .rdata(kv_rdata)
	);

	// Read the group start on accept, then the slot after the one in hand
	assign raddr = (state_q == stl_pkg::S_IDLE) ? in_base : rd_slot_s1 + 1'b1;

	// Next state and memory writes
	always_comb begin
		state_d = state_q;
		c_we = 1'b0;
		c_waddr = clr_q;
		c_wdata = stl_pkg::EMPTY_MARK;
		kv_we = 1'b0;
		unique case (state_q)
			stl_pkg::S_CLEAR: begin
				c_we = 1'b1;
				if (clr_q == AW'(CAPACITY - 1)) begin
					state_d = stl_pkg::S_IDLE;
				end
			end
			stl_pkg::S_IDLE: begin
				if (accept) begin
					state_d = stl_pkg::S_READ;
				end
			end
			stl_pkg::S_READ: begin
				if (is_hit || probe_end) begin
					state_d = stl_pkg::S_CHECK;
				end
			end
			stl_pkg::S_CHECK: begin
				state_d = stl_pkg::S_DONE;
				if (req_q.operation == stl_pkg::OP_INSERT) begin
					if (hit_q) begin
						kv_we = 1'b1;
					end else if (have_empty_q && count_q < CW'(load_limit_q)) begin
						kv_we = 1'b1;
						c_we = 1'b1;
						c_waddr = empty_q;
						c_wdata = {1'b0, tag_q};
					end
				end
			end
			stl_pkg::S_WRITE: begin
				state_d = stl_pkg::S_DONE;
			end
			stl_pkg::S_DONE: begin
				if (!out_stall) begin
					state_d = stl_pkg::S_IDLE;
				end
			end
			default: state_d = stl_pkg::S_IDLE;
		endcase
	end

	// Hold state, sweep pointer, load limit, entry count and read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stl_pkg::S_CLEAR;
			clr_q <= '0;
			load_limit_q <= stl_pkg::LOAD_LIMIT_RST;
			count_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == stl_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				load_limit_q <= cfg_data;
			end
			if (state_q == stl_pkg::S_CHECK && c_we) begin
				count_q <= count_q + 1'b1;
			end
			rd_valid_s1 <= accept
				|| ((state_q == stl_pkg::S_READ) && !is_hit && !probe_end);
		end
	end

	// Capture the request, advance the probe and note hits and empties
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
			tag_q <= habs[stl_pkg::TAG_SHIFT +: 7];
			probed_q <= CW'(1);
			have_empty_q <= 1'b0;
			empty_q <= '0;
			hit_q <= 1'b0;
			hit_slot_q <= '0;
			rd_idx_s1 <= '0;
			rd_slot_s1 <= in_base;
		end else if (state_q == stl_pkg::S_READ) begin
			if (is_hit) begin
				hit_q <= 1'b1;
				hit_slot_q <= rd_slot_s1;
				hit_val_q <= kv_rdata[63:0];
			end
			if (slot_free && !have_empty_q) begin
				have_empty_q <= 1'b1;
				empty_q <= rd_slot_s1;
			end
			probed_q <= probed_q + 1'b1;
			rd_idx_s1 <= rd_idx_s1 + 1'b1;
			rd_slot_s1 <= rd_slot_s1 + 1'b1;
		end
	end

	// Form the result on CHECK
	always_ff @(posedge clk) begin
		if (state_q == stl_pkg::S_CHECK) begin
			rsp_q.read_value <= '0;
			rsp_q.slot <= '0;
			rsp_q.entry_total <= 8'(count_q);
			if (hit_q) begin
				rsp_q.slot <= 7'(hit_slot_q);
				if (req_q.operation == stl_pkg::OP_LOOKUP) begin
					rsp_q.status <= stl_pkg::ST_FOUND;
					rsp_q.read_value <= hit_val_q;
				end else begin
					rsp_q.status <= stl_pkg::ST_UPDATED;
				end
			end else if (req_q.operation == stl_pkg::OP_LOOKUP) begin
				rsp_q.status <= stl_pkg::ST_MISSING;
			end else if (have_empty_q && count_q < CW'(load_limit_q)) begin
				rsp_q.status <= stl_pkg::ST_INSERTED;
				rsp_q.slot <= 7'(empty_q);
				rsp_q.entry_total <= 8'(count_q + 1'b1);
			end else begin
				rsp_q.status <= stl_pkg::ST_FULL;
			end
		end
	end

endmodule

// ===== sv/stl_checker.sv =====
// Port-level checker for the hash map block, bound to the top level.
// Depends on stl_pkg and swiss_table_lookup_insert.
module stl_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input stl_pkg::rsp_t out_data
);

	// A result never comes while a request is being taken
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result shown while request accepted");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Status is a defined code
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= stl_pkg::ST_FULL)
		else $error("bad status");

	// Entry total never exceeds capacity
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.entry_total <= 8'd128)
		else $error("entry total out of range");

endmodule

bind swiss_table_lookup_insert stl_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
